// ----- design/rqch_pkg.sv -----
package rqch_pkg;

  localparam int unsigned MaxQuadsDef = 64;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned AccW = 66;

  localparam logic [1:0] KindClear  = 2'd0;
  localparam logic [1:0] KindAppend = 2'd1;
  localparam logic [1:0] KindTrace  = 2'd2;

  typedef logic signed [31:0] s32_t;

  localparam s32_t S32Max = 32'sh7fff_ffff;
  localparam s32_t S32Min = 32'sh8000_0000;
  localparam logic signed [AccW-1:0] AccMax = 66'sd2147483647;
  localparam logic signed [AccW-1:0] AccMin = -66'sd2147483648;

  typedef struct packed {
    logic [1:0]  kind;
    s32_t        point_x;
    s32_t        point_y;
    s32_t        point_z;
    s32_t        axis_x;
    s32_t        axis_y;
    s32_t        axis_z;
    s32_t        tangent_x;
    s32_t        tangent_y;
    s32_t        tangent_z;
    logic [30:0] width;
    logic [30:0] height;
  } rqch_in_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  hit_quad;
    logic [30:0] hit_distance;
    logic [16:0] hit_u;
    logic [16:0] hit_v;
    logic        overflow;
  } rqch_out_t;

  typedef struct packed {
    s32_t [2:0]        center;
    s32_t [2:0]        normal;
    s32_t [2:0]        tangent;
    s32_t [2:0]        bitangent;
    logic [1:0][30:0]  half;
    logic [1:0][30:0]  inv;
  } quad_rec_t;

  typedef struct packed {
    logic       start;
    logic [1:0] cnt;
    logic [2:0] sub;
    logic       raw;
    s32_t       init;
    s32_t [2:0] a;
    s32_t [2:0] b;
  } mac_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [AccW-1:0] acc;
  } mac_rsp_t;

  function automatic logic signed [AccW-1:0] sx66(input s32_t v);
    return {{(AccW-32){v[31]}}, v};
  endfunction

  function automatic s32_t sat32(input logic signed [AccW-1:0] v);
    s32_t r;
    if (v > AccMax) begin
      r = S32Max;
    end else if (v < AccMin) begin
      r = S32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input s32_t v);
    logic [31:0] r;
    r = v;
    if (v[31]) begin
      r = ~r + 32'd1;
    end
    return r;
  endfunction

endpackage

// ----- design/rqch_mac.sv -----
module rqch_mac import rqch_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  localparam logic [63:0] LowMask = (64'd1 << FracBits) - 64'd1;

  s32_t [2:0]             a_q, b_q;
  logic [2:0]             sub_q;
  logic                   raw_q, busy_q, pend_q, psub_q, done_q;
  logic [1:0]             cnt_q, idx_q;
  logic signed [63:0]     prod_q;
  logic signed [AccW-1:0] acc_q;

  logic signed [63:0]     shr;
  logic                   low_nz;
  logic signed [AccW-1:0] term;

  always_comb begin
    shr    = prod_q >>> FracBits;
    low_nz = |(prod_q & LowMask);
    if (raw_q) begin
      term = {{(AccW-64){prod_q[63]}}, prod_q};
    end else begin
      term = {{(AccW-64){shr[63]}}, shr} +
             {{(AccW-1){1'b0}}, prod_q[63] & low_nz};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      sub_q  <= '0;
      raw_q  <= 1'b0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      psub_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      idx_q  <= '0;
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        sub_q  <= req_i.sub;
        raw_q  <= req_i.raw;
        cnt_q  <= req_i.cnt;
        idx_q  <= '0;
        pend_q <= 1'b0;
        busy_q <= 1'b1;
        acc_q  <= sx66(req_i.init);
      end else if (busy_q) begin
        if (idx_q < cnt_q) begin
          prod_q <= $signed(a_q[idx_q]) * $signed(b_q[idx_q]);
          psub_q <= sub_q[idx_q];
          idx_q  <= idx_q + 2'd1;
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
        if (pend_q) begin
          acc_q <= psub_q ? acc_q - term : acc_q + term;
        end
        if (idx_q == cnt_q && pend_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;

endmodule

// ----- design/rqch_div.sv -----
module rqch_div import rqch_pkg::*; #(
  parameter int unsigned NW = 32 + FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [31:0]   den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [31:0]   rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic          busy_q, done_q;

  logic [32:0]   trial, diff;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
        cnt_q  <= CntW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!diff[32]) begin
          rem_q <= diff[31:0];
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- design/rqch_isqrt.sv -----
module rqch_isqrt import rqch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, res_q, one_q;
  logic        busy_q, done_q;
  logic [63:0] sum;

  assign sum = res_q + one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      res_q  <= '0;
      one_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= rad_i;
        res_q  <= '0;
        one_q  <= 64'd1 << 62;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (x_q >= sum) begin
          x_q   <= x_q - sum;
          res_q <= (res_q >> 1) + one_q;
        end else begin
          res_q <= res_q >> 1;
        end
        one_q <= one_q >> 2;
        if (one_q == 64'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ----- design/rqch_ram.sv -----
module rqch_ram import rqch_pkg::*; #(
  parameter int unsigned Depth = MaxQuadsDef,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] waddr_i,
  input  quad_rec_t     wdata_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] raddr_i,
  output quad_rec_t     rdata_o
);

  quad_rec_t rec_mem_q [Depth];
  quad_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rec_mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= rec_mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ray_quad_closest_hit_unit.sv -----
// closest hit of a ray against a table of oriented rectangles
// input channel in_valid_i / in_stall_o / in_word_i carries one command word:
// clear empties the table and the overflow flag, append stores one quad
// (normal and tangent normalized, bitangent and reciprocal half sizes formed)
// or sets the overflow flag when the table is full; trace walks every stored
// quad and gives one result word on the output channel out_valid_o /
// out_stall_i / out_word_o. clear and append give none. one command is worked
// at a time; in_stall_o is high until it is finished. append forms two square
// roots and up to 8 serial divisions; trace uses, per stored quad, the serial
// divider and the shared multiply-accumulate unit on the hit path, and stops
// sooner when the ray is parallel or the plane lies behind.
// the quad table is one synchronous memory, one entry per quad.
// reset empties the table and clears the overflow flag and output valid.
// a finished result waits in the output register while out_stall_i is high;
// the next command is taken meanwhile, a new trace waits for the register.
module ray_quad_closest_hit_unit import rqch_pkg::*; #(
  parameter int unsigned MaxQuads = MaxQuadsDef,
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rqch_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rqch_out_t out_word_o
);

  localparam int unsigned AW = (MaxQuads > 1) ? $clog2(MaxQuads) : 1;
  localparam int unsigned CW = $clog2(MaxQuads + 1);
  localparam int unsigned NW = 32 + FracBits;
  localparam logic [NW-1:0] InvNum = NW'(1) << (2 * FracBits + 1);
  localparam s32_t HalfOne = s32_t'(1) <<< (FracBits - 1);

  localparam logic [4:0] SIdle   = 5'd0;
  localparam logic [4:0] SDecode = 5'd1;
  localparam logic [4:0] ASq     = 5'd2;
  localparam logic [4:0] ASqrt   = 5'd3;
  localparam logic [4:0] ADiv    = 5'd4;
  localparam logic [4:0] ADivW   = 5'd5;
  localparam logic [4:0] AStore  = 5'd6;
  localparam logic [4:0] ACross  = 5'd7;
  localparam logic [4:0] ACrossW = 5'd8;
  localparam logic [4:0] AInv    = 5'd9;
  localparam logic [4:0] AInvW   = 5'd10;
  localparam logic [4:0] AWrite  = 5'd11;
  localparam logic [4:0] TNext   = 5'd12;
  localparam logic [4:0] TRead   = 5'd13;
  localparam logic [4:0] THgt    = 5'd14;
  localparam logic [4:0] THgtW   = 5'd15;
  localparam logic [4:0] TSlpW   = 5'd16;
  localparam logic [4:0] TDiv    = 5'd17;
  localparam logic [4:0] TDivW   = 5'd18;
  localparam logic [4:0] THp     = 5'd19;
  localparam logic [4:0] THpW    = 5'd20;
  localparam logic [4:0] TFrom   = 5'd21;
  localparam logic [4:0] TDx     = 5'd22;
  localparam logic [4:0] TDxW    = 5'd23;
  localparam logic [4:0] TDyW    = 5'd24;
  localparam logic [4:0] TChk    = 5'd25;
  localparam logic [4:0] TUW     = 5'd26;
  localparam logic [4:0] TVW     = 5'd27;
  localparam logic [4:0] TSkip   = 5'd28;
  localparam logic [4:0] TOut    = 5'd29;

  function automatic logic [16:0] uv_clamp(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] one;
    logic [16:0] r;
    one = {{(AccW-1){1'b0}}, 1'b1} <<< FracBits;
    if (v < 0) begin
      r = '0;
    end else if (v > one) begin
      r = one[16:0];
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  logic [4:0]      state_q;
  rqch_in_t        item_q;
  logic [CW-1:0]   count_q, qi_q;
  logic            ovf_q, phase_q, dneg_q;
  s32_t [2:0]      vec_q, nrm_q, tng_q, btn_q, toc_q, fromc_q;
  logic [31:0]     len_q;
  logic [1:0]      ci_q;
  logic [1:0][30:0] inv_q;
  s32_t            height_q, slope_q, dx_q, dy_q;
  logic [30:0]     d_q, best_d_q;
  logic [16:0]     uu_q, best_u_q, best_v_q;
  logic            hit_q;
  logic [AW-1:0]   best_idx_q;
  logic            out_valid_q;
  rqch_out_t       out_q;
  mac_req_t        mac_req_q;
  logic            div_start_q, sq_start_q;
  logic [NW-1:0]   div_num_q;
  logic [31:0]     div_den_q;

  mac_rsp_t        mac_rsp;
  logic            div_done, sq_done;
  logic [NW-1:0]   div_quo;
  logic [31:0]     sq_root;
  quad_rec_t       rec, wrec;
  logic            rd_en, wr_en;

  s32_t [2:0]      pnt, axs, tgt;
  logic [1:0]      cj, ck;
  logic            quo_big;
  logic [30:0]     quo_sat;
  s32_t            comp;
  logic signed [NW:0] squo;
  logic [AW+5:0]   qidx;
  logic            in_acc;

  assign pnt = {item_q.point_z, item_q.point_y, item_q.point_x};
  assign axs = {item_q.axis_z, item_q.axis_y, item_q.axis_x};
  assign tgt = {item_q.tangent_z, item_q.tangent_y, item_q.tangent_x};

  always_comb begin
    case (ci_q)
      2'd0: begin
        cj = 2'd1;
        ck = 2'd2;
      end
      2'd1: begin
        cj = 2'd2;
        ck = 2'd0;
      end
      default: begin
        cj = 2'd0;
        ck = 2'd1;
      end
    endcase
    quo_big = div_quo > NW'(S32Max);
    quo_sat = quo_big ? S32Max[30:0] : div_quo[30:0];
    squo    = vec_q[ci_q][31] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    comp    = (len_q == 32'd0) ? '0 : sat32({{(AccW-NW-1){squo[NW]}}, squo});
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign rd_en  = (state_q == TNext) && (qi_q < count_q);
  assign wr_en  = (state_q == AWrite);

  always_comb begin
    wrec.center    = pnt;
    wrec.normal    = nrm_q;
    wrec.tangent   = tng_q;
    wrec.bitangent = btn_q;
    wrec.half      = {1'b0, item_q.height[30:1], 1'b0, item_q.width[30:1]};
    wrec.inv       = inv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      item_q      <= '0;
      count_q     <= '0;
      qi_q        <= '0;
      ovf_q       <= 1'b0;
      phase_q     <= 1'b0;
      dneg_q      <= 1'b0;
      vec_q       <= '0;
      nrm_q       <= '0;
      tng_q       <= '0;
      btn_q       <= '0;
      toc_q       <= '0;
      fromc_q     <= '0;
      len_q       <= '0;
      ci_q        <= '0;
      inv_q       <= '0;
      height_q    <= '0;
      slope_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      d_q         <= '0;
      best_d_q    <= '0;
      uu_q        <= '0;
      best_u_q    <= '0;
      best_v_q    <= '0;
      hit_q       <= 1'b0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      mac_req_q   <= '0;
      div_start_q <= 1'b0;
      sq_start_q  <= 1'b0;
      div_num_q   <= '0;
      div_den_q   <= '0;
    end else begin
      mac_req_q.start <= 1'b0;
      div_start_q     <= 1'b0;
      sq_start_q      <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_acc) begin
            item_q  <= in_word_i;
            state_q <= SDecode;
          end
        end
        SDecode: begin
          case (item_q.kind)
            KindClear: begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= SIdle;
            end
            KindAppend: begin
              if (count_q >= CW'(MaxQuads)) begin
                ovf_q   <= 1'b1;
                state_q <= SIdle;
              end else begin
                phase_q         <= 1'b0;
                vec_q           <= axs;
                mac_req_q.start <= 1'b1;
                mac_req_q.cnt   <= 2'd3;
                mac_req_q.sub   <= 3'b000;
                mac_req_q.raw   <= 1'b1;
                mac_req_q.init  <= '0;
                mac_req_q.a     <= axs;
                mac_req_q.b     <= axs;
                state_q         <= ASq;
              end
            end
            KindTrace: begin
              hit_q      <= 1'b0;
              best_idx_q <= '0;
              best_d_q   <= S32Max[30:0];
              best_u_q   <= '0;
              best_v_q   <= '0;
              qi_q       <= '0;
              state_q    <= TNext;
            end
            default: begin
              state_q <= SIdle;
            end
          endcase
        end
        ASq: begin
          if (mac_rsp.done) begin
            sq_start_q <= 1'b1;
            state_q    <= ASqrt;
          end
        end
        ASqrt: begin
          if (sq_done) begin
            len_q   <= sq_root;
            ci_q    <= '0;
            state_q <= ADiv;
          end
        end
        ADiv: begin
          if (len_q == 32'd0) begin
            state_q <= AStore;
          end else begin
            div_start_q <= 1'b1;
            div_num_q   <= {abs32(vec_q[ci_q]), {FracBits{1'b0}}};
            div_den_q   <= len_q;
            state_q     <= ADivW;
          end
        end
        ADivW: begin
          if (div_done) begin
            state_q <= AStore;
          end
        end
        AStore: begin
          if (!phase_q) begin
            nrm_q[ci_q] <= comp;
          end else begin
            tng_q[ci_q] <= comp;
          end
          if (ci_q != 2'd2) begin
            ci_q    <= ci_q + 2'd1;
            state_q <= ADiv;
          end else if (!phase_q) begin
            phase_q         <= 1'b1;
            vec_q           <= tgt;
            mac_req_q.start <= 1'b1;
            mac_req_q.a     <= tgt;
            mac_req_q.b     <= tgt;
            state_q         <= ASq;
          end else begin
            ci_q    <= '0;
            state_q <= ACross;
          end
        end
        ACross: begin
          mac_req_q.start <= 1'b1;
          mac_req_q.cnt   <= 2'd2;
          mac_req_q.sub   <= 3'b010;
          mac_req_q.raw   <= 1'b0;
          mac_req_q.init  <= '0;
          mac_req_q.a     <= {s32_t'(0), nrm_q[ck], nrm_q[cj]};
          mac_req_q.b     <= {s32_t'(0), tng_q[cj], tng_q[ck]};
          state_q         <= ACrossW;
        end
        ACrossW: begin
          if (mac_rsp.done) begin
            btn_q[ci_q] <= sat32(mac_rsp.acc);
            if (ci_q == 2'd2) begin
              ci_q    <= '0;
              state_q <= AInv;
            end else begin
              ci_q    <= ci_q + 2'd1;
              state_q <= ACross;
            end
          end
        end
        AInv: begin
          if ((ci_q[0] ? item_q.height : item_q.width) == 31'd0) begin
            inv_q[ci_q[0]] <= S32Max[30:0];
            if (ci_q[0]) begin
              state_q <= AWrite;
            end else begin
              ci_q <= 2'd1;
            end
          end else begin
            div_start_q <= 1'b1;
            div_num_q   <= InvNum;
            div_den_q   <= {1'b0, ci_q[0] ? item_q.height : item_q.width};
            state_q     <= AInvW;
          end
        end
        AInvW: begin
          if (div_done) begin
            inv_q[ci_q[0]] <= quo_sat;
            if (ci_q[0]) begin
              state_q <= AWrite;
            end else begin
              ci_q    <= 2'd1;
              state_q <= AInv;
            end
          end
        end
        AWrite: begin
          count_q <= count_q + CW'(1);
          state_q <= SIdle;
        end
        TNext: begin
          state_q <= (qi_q < count_q) ? TRead : TOut;
        end
        TRead: begin
          for (int i = 0; i < 3; i++) begin
            toc_q[i] <= sat32(sx66(rec.center[i]) - sx66(pnt[i]));
          end
          state_q <= THgt;
        end
        THgt: begin
          mac_req_q.start <= 1'b1;
          mac_req_q.cnt   <= 2'd3;
          mac_req_q.sub   <= 3'b000;
          mac_req_q.raw   <= 1'b0;
          mac_req_q.init  <= '0;
          mac_req_q.a     <= toc_q;
          mac_req_q.b     <= rec.normal;
          state_q         <= THgtW;
        end
        THgtW: begin
          if (mac_rsp.done) begin
            height_q        <= sat32(mac_rsp.acc);
            mac_req_q.start <= 1'b1;
            mac_req_q.a     <= axs;
            state_q         <= TSlpW;
          end
        end
        TSlpW: begin
          if (mac_rsp.done) begin
            slope_q <= sat32(mac_rsp.acc);
            state_q <= TDiv;
          end
        end
        TDiv: begin
          if (slope_q == 32'sd0) begin
            state_q <= TSkip;
          end else begin
            div_start_q <= 1'b1;
            div_num_q   <= {abs32(height_q), {FracBits{1'b0}}};
            div_den_q   <= abs32(slope_q);
            dneg_q      <= height_q[31] ^ slope_q[31];
            state_q     <= TDivW;
          end
        end
        TDivW: begin
          if (div_done) begin
            if (dneg_q || div_quo == '0 || quo_sat > best_d_q) begin
              state_q <= TSkip;
            end else begin
              d_q     <= quo_sat;
              ci_q    <= '0;
              state_q <= THp;
            end
          end
        end
        THp: begin
          mac_req_q.start <= 1'b1;
          mac_req_q.cnt   <= 2'd1;
          mac_req_q.sub   <= 3'b000;
          mac_req_q.raw   <= 1'b0;
          mac_req_q.init  <= pnt[ci_q];
          mac_req_q.a     <= {s32_t'(0), s32_t'(0), s32_t'({1'b0, d_q})};
          mac_req_q.b     <= {s32_t'(0), s32_t'(0), axs[ci_q]};
          state_q         <= THpW;
        end
        THpW: begin
          if (mac_rsp.done) begin
            fromc_q[ci_q] <= sat32(mac_rsp.acc);
            if (ci_q == 2'd2) begin
              state_q <= TFrom;
            end else begin
              ci_q    <= ci_q + 2'd1;
              state_q <= THp;
            end
          end
        end
        TFrom: begin
          for (int i = 0; i < 3; i++) begin
            fromc_q[i] <= sat32(sx66(fromc_q[i]) - sx66(rec.center[i]));
          end
          state_q <= TDx;
        end
        TDx: begin
          mac_req_q.start <= 1'b1;
          mac_req_q.cnt   <= 2'd3;
          mac_req_q.init  <= '0;
          mac_req_q.a     <= fromc_q;
          mac_req_q.b     <= rec.tangent;
          state_q         <= TDxW;
        end
        TDxW: begin
          if (mac_rsp.done) begin
            dx_q            <= sat32(mac_rsp.acc);
            mac_req_q.start <= 1'b1;
            mac_req_q.b     <= rec.bitangent;
            state_q         <= TDyW;
          end
        end
        TDyW: begin
          if (mac_rsp.done) begin
            dy_q    <= sat32(mac_rsp.acc);
            state_q <= TChk;
          end
        end
        TChk: begin
          if (abs32(dx_q) > {1'b0, rec.half[0]} || abs32(dy_q) > {1'b0, rec.half[1]}) begin
            state_q <= TSkip;
          end else begin
            mac_req_q.start <= 1'b1;
            mac_req_q.cnt   <= 2'd1;
            mac_req_q.init  <= HalfOne;
            mac_req_q.a     <= {s32_t'(0), s32_t'(0), dx_q};
            mac_req_q.b     <= {s32_t'(0), s32_t'(0), s32_t'({1'b0, rec.inv[0]})};
            state_q         <= TUW;
          end
        end
        TUW: begin
          if (mac_rsp.done) begin
            uu_q            <= uv_clamp(mac_rsp.acc);
            mac_req_q.start <= 1'b1;
            mac_req_q.a     <= {s32_t'(0), s32_t'(0), dy_q};
            mac_req_q.b     <= {s32_t'(0), s32_t'(0), s32_t'({1'b0, rec.inv[1]})};
            state_q         <= TVW;
          end
        end
        TVW: begin
          if (mac_rsp.done) begin
            hit_q      <= 1'b1;
            best_d_q   <= d_q;
            best_idx_q <= qi_q[AW-1:0];
            best_u_q   <= uu_q;
            best_v_q   <= uv_clamp(mac_rsp.acc);
            state_q    <= TSkip;
          end
        end
        TSkip: begin
          qi_q    <= qi_q + CW'(1);
          state_q <= TNext;
        end
        TOut: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.hit          <= hit_q;
            out_q.hit_quad     <= qidx[5:0];
            out_q.hit_distance <= best_d_q;
            out_q.hit_u        <= best_u_q;
            out_q.hit_v        <= best_v_q;
            out_q.overflow     <= ovf_q;
            out_valid_q        <= 1'b1;
            state_q            <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign qidx = {6'd0, best_idx_q};

  rqch_mac #(.FracBits(FracBits)) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mac_req_q),
    .rsp_o (mac_rsp)
  );

  rqch_div #(.NW(NW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  rqch_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start_q),
    .rad_i  (mac_rsp.acc[63:0]),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  rqch_ram #(.Depth(MaxQuads), .AW(AW)) u_ram (
    .clk_i  (clk_i),
    .wr_en_i(wr_en),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(wrec),
    .rd_en_i(rd_en),
    .raddr_i(qi_q[AW-1:0]),
    .rdata_o(rec)
  );

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- design/rqch_checker.sv -----
module rqch_checker import rqch_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input rqch_out_t out_word_o
);

  // one command at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a command is in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a trace in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  a_miss_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.hit |-> out_word_o.hit_quad == 6'd0 &&
      out_word_o.hit_distance == 31'h7fff_ffff && out_word_o.hit_u == 17'd0 &&
      out_word_o.hit_v == 17'd0)
    else $error("miss word not in its default form");

  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.hit |-> out_word_o.hit_distance != 31'd0)
    else $error("hit at zero distance");

endmodule

bind ray_quad_closest_hit_unit rqch_checker u_chk (.*);

// ----- tb/ray_quad_closest_hit_unit_tb.sv -----
`timescale 1ns / 1ps

module ray_quad_closest_hit_unit_tb;
  import rqch_pkg::*;

  localparam int unsigned NumQuads = 64;
  localparam int unsigned Frac = 16;
  localparam longint LimMax = 64'sd2147483647;
  localparam longint LimMin = -64'sd2147483648;
  localparam longint CycleLimit = 64'd3_000_000;
  localparam logic [1:0] KindUnused = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  rqch_in_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  rqch_out_t out_word_o;

  ray_quad_closest_hit_unit i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o)
  );

  // scene copy
  longint scene_c[NumQuads][3];
  longint scene_n[NumQuads][3];
  longint scene_t[NumQuads][3];
  longint scene_b[NumQuads][3];
  longint scene_half[NumQuads][2];
  longint scene_inv[NumQuads][2];
  int unsigned scene_count;
  bit scene_dropped;

  rqch_out_t hits_due[$];
  int unsigned error_count;
  longint cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic longint clamp32(longint v);
    if (v > LimMax) return LimMax;
    if (v < LimMin) return LimMin;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    if (p < 0) return -((-p) >>> Frac);
    return p >>> Frac;
  endfunction

  function automatic longint fx_div(longint n, longint d);
    bit neg;
    longint unsigned mn;
    longint unsigned md;
    longint unsigned q;
    neg = (n < 0) != (d < 0);
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    q = (mn << Frac) / md;
    if (q > (64'd1 << 62)) q = 64'd1 << 62;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint fx_dot(longint a0, longint a1, longint a2,
                                    longint b0, longint b1, longint b2);
    return clamp32(fx_mul(a0, b0) + fx_mul(a1, b1) + fx_mul(a2, b2));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(longint v, longint unsigned len);
    longint unsigned m;
    longint unsigned q;
    if (len == 0) return 0;
    m = v < 0 ? -v : v;
    q = (m << Frac) / len;
    return clamp32(v < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint recip_half(longint unsigned size);
    longint unsigned q;
    if (size == 0) return LimMax;
    q = (64'd2 << (2 * Frac)) / size;
    return q > LimMax ? LimMax : longint'(q);
  endfunction

  function automatic longint uv_coord(longint d, longint inv);
    longint one;
    longint u;
    one = 64'sd1 << Frac;
    u = (one >>> 1) + fx_mul(d, inv);
    if (u < 0) u = 0;
    if (u > one) u = one;
    return u;
  endfunction

  task automatic store_quad(input rqch_in_t w);
    longint a[3];
    longint t[3];
    longint unsigned la;
    longint unsigned lt;
    int q;
    if (scene_count >= NumQuads) begin
      scene_dropped = 1'b1;
      return;
    end
    q = scene_count;
    a = '{w.axis_x, w.axis_y, w.axis_z};
    t = '{w.tangent_x, w.tangent_y, w.tangent_z};
    scene_c[q] = '{w.point_x, w.point_y, w.point_z};
    la = int_sqrt(longint'(a[0] * a[0]) + longint'(a[1] * a[1]) + longint'(a[2] * a[2]));
    lt = int_sqrt(longint'(t[0] * t[0]) + longint'(t[1] * t[1]) + longint'(t[2] * t[2]));
    for (int i = 0; i < 3; i++) begin
      scene_n[q][i] = unit_comp(a[i], la);
      scene_t[q][i] = unit_comp(t[i], lt);
    end
    scene_b[q][0] = clamp32(fx_mul(scene_n[q][1], scene_t[q][2]) -
                            fx_mul(scene_n[q][2], scene_t[q][1]));
    scene_b[q][1] = clamp32(fx_mul(scene_n[q][2], scene_t[q][0]) -
                            fx_mul(scene_n[q][0], scene_t[q][2]));
    scene_b[q][2] = clamp32(fx_mul(scene_n[q][0], scene_t[q][1]) -
                            fx_mul(scene_n[q][1], scene_t[q][0]));
    scene_half[q] = '{w.width >> 1, w.height >> 1};
    scene_inv[q] = '{recip_half(w.width), recip_half(w.height)};
    scene_count++;
  endtask

  function automatic rqch_out_t trace_closest(rqch_in_t w);
    rqch_out_t r;
    longint p[3];
    longint a[3];
    longint tc[3];
    longint fc[3];
    longint ht;
    longint sl;
    longint d;
    longint dx;
    longint dy;
    longint best_d;
    longint best_u;
    longint best_v;
    int best_q;
    bit found;
    p = '{w.point_x, w.point_y, w.point_z};
    a = '{w.axis_x, w.axis_y, w.axis_z};
    best_d = LimMax;
    best_u = 0;
    best_v = 0;
    best_q = 0;
    found = 1'b0;
    for (int q = 0; q < scene_count; q++) begin
      for (int i = 0; i < 3; i++) tc[i] = clamp32(scene_c[q][i] - p[i]);
      ht = fx_dot(tc[0], tc[1], tc[2], scene_n[q][0], scene_n[q][1], scene_n[q][2]);
      sl = fx_dot(a[0], a[1], a[2], scene_n[q][0], scene_n[q][1], scene_n[q][2]);
      if (sl == 0) continue;
      d = clamp32(fx_div(ht, sl));
      if (d <= 0 || d > best_d) continue;
      for (int i = 0; i < 3; i++) begin
        fc[i] = clamp32(clamp32(p[i] + fx_mul(d, a[i])) - scene_c[q][i]);
      end
      dx = fx_dot(fc[0], fc[1], fc[2], scene_t[q][0], scene_t[q][1], scene_t[q][2]);
      dy = fx_dot(fc[0], fc[1], fc[2], scene_b[q][0], scene_b[q][1], scene_b[q][2]);
      if ((dx < 0 ? -dx : dx) > scene_half[q][0] ||
          (dy < 0 ? -dy : dy) > scene_half[q][1]) continue;
      found = 1'b1;
      best_d = d;
      best_q = q;
      best_u = uv_coord(dx, scene_inv[q][0]);
      best_v = uv_coord(dy, scene_inv[q][1]);
    end
    r.hit = found;
    r.hit_quad = best_q[5:0];
    r.hit_distance = best_d[30:0];
    r.hit_u = best_u[16:0];
    r.hit_v = best_v[16:0];
    r.overflow = scene_dropped;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic send_word(input rqch_in_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_word_i <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (w.kind)
      KindClear: begin
        scene_count = 0;
        scene_dropped = 1'b0;
      end
      KindAppend: store_quad(w);
      KindTrace: hits_due.push_back(trace_closest(w));
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // result checker
  initial begin
    rqch_out_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (hits_due.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          e = hits_due.pop_front();
          if (out_word_o.hit !== e.hit) report_mismatch("hit", out_word_o.hit, e.hit);
          if (out_word_o.hit_quad !== e.hit_quad)
            report_mismatch("hit_quad", out_word_o.hit_quad, e.hit_quad);
          if (out_word_o.hit_distance !== e.hit_distance)
            report_mismatch("hit_distance", out_word_o.hit_distance, e.hit_distance);
          if (out_word_o.hit_u !== e.hit_u) report_mismatch("hit_u", out_word_o.hit_u, e.hit_u);
          if (out_word_o.hit_v !== e.hit_v) report_mismatch("hit_v", out_word_o.hit_v, e.hit_v);
          if (out_word_o.overflow !== e.overflow)
            report_mismatch("overflow", out_word_o.overflow, e.overflow);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_axis();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 0;
      default: return $signed($urandom_range(2 << 16)) - (1 << 16);
    endcase
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(5))
      0: return 31'($urandom);
      1: return $urandom_range(1) ? 31'h7fff_ffff : 31'd1;
      default: return 31'($urandom_range(1, 12 << 16));
    endcase
  endfunction

  function automatic rqch_in_t make_quad();
    rqch_in_t w;
    w.kind = KindAppend;
    w.point_x = rand_coord();
    w.point_y = rand_coord();
    w.point_z = rand_coord();
    w.axis_x = rand_axis();
    w.axis_y = rand_axis();
    w.axis_z = rand_axis();
    w.tangent_x = rand_axis();
    w.tangent_y = rand_axis();
    w.tangent_z = rand_axis();
    w.width = rand_size();
    w.height = rand_size();
    return w;
  endfunction

  function automatic rqch_in_t make_ray();
    rqch_in_t w;
    w = make_quad();
    w.kind = KindTrace;
    w.tangent_x = $urandom;
    w.tangent_y = $urandom;
    w.tangent_z = $urandom;
    w.width = 31'($urandom);
    w.height = 31'($urandom);
    return w;
  endfunction

  function automatic rqch_in_t make_cmd(logic [1:0] k);
    rqch_in_t w;
    w = make_ray();
    w.kind = k;
    return w;
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (hits_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    rqch_in_t w;
    send_word(make_cmd(KindTrace));
    // 2 by 2 square facing z at origin
    w = '0;
    w.kind = KindAppend;
    w.axis_z = 32'sh0001_0000;
    w.tangent_x = 32'sh0003_0000;
    w.width = 31'h0002_0000;
    w.height = 31'h0002_0000;
    send_word(w);
    // same plane again for a distance tie, zero vectors and zero sizes
    send_word(w);
    w.axis_z = 0;
    w.tangent_x = 0;
    w.width = 0;
    w.height = 0;
    send_word(w);
    w = '0;
    w.kind = KindTrace;
    w.point_z = -32'sh0005_0000;
    w.axis_z = 32'sh0001_0000;
    send_word(w);
    w.point_x = 32'sh0000_8000;
    w.point_y = -32'sh0000_4000;
    send_word(w);
    w.axis_z = -32'sh0001_0000;
    send_word(w);
    w.axis_z = 0;
    w.axis_x = 32'sh0001_0000;
    send_word(w);
    w.point_x = 32'sh7fff_ffff;
    w.point_y = 32'sh8000_0000;
    w.point_z = 32'sh8000_0000;
    w.axis_x = 32'sh8000_0000;
    w.axis_y = 32'sh7fff_ffff;
    w.axis_z = 32'sh7fff_ffff;
    send_word(w);
    w = make_quad();
    w.axis_x = 32'sh7fff_ffff;
    w.axis_y = 32'sh8000_0000;
    w.tangent_z = 32'sh8000_0000;
    w.width = 31'h7fff_ffff;
    w.height = 31'd1;
    send_word(w);
    send_word(make_cmd(KindUnused));
    send_word(make_cmd(KindTrace));
    send_word(make_cmd(KindClear));
    send_word(make_cmd(KindTrace));
    drain_results();
  endtask

  task automatic test_overflow();
    send_word(make_cmd(KindClear));
    for (int i = 0; i < NumQuads + 2; i++) send_word(make_quad());
    send_word(make_ray());
    send_word(make_ray());
    send_word(make_cmd(KindClear));
    send_word(make_ray());
    drain_results();
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned nq;
    sent = 0;
    while (sent < n_items) begin
      send_word(make_cmd(KindClear));
      nq = $urandom_range(6) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 4);
      for (int i = 0; i < nq; i++) send_word(make_quad());
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(19))
          0: send_word(make_quad());
          1: send_word(make_cmd(KindUnused));
          default: send_word(make_ray());
        endcase
      end
      sent += nq + 9;
      if ($urandom_range(9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    scene_count = 0;
    scene_dropped = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 66;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow();
    test_random(450);
    send_idle_pct = 66;
    recv_idle_pct = 29;
    test_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(450);
    drain_results();
    repeat (200) @(negedge clk_i);
    if (error_count == 0 && hits_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
